### hw/rtl/sorted_timer_event_queue_top_defines.svh
// Assertion macros for the sorted timer event queue.
`ifndef SORTED_TIMER_EVENT_QUEUE_TOP_DEFINES_SVH
`define SORTED_TIMER_EVENT_QUEUE_TOP_DEFINES_SVH

`ifndef SYNTH

`define STQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define STQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define STQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define STQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/stq_pkg.sv
// Shared codes and controller/datapath interface types for the timer queue.
package stq_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_SCHEDULE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CANCEL   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN      = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DUPLICATE  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_QUEUED = 2'd3;

  typedef struct packed {
    logic                cap;
    logic                cmp;
    logic                ins;
    logic                rem_match;
    logic                rem_head;
    logic                set_res;
    logic                res_fired;
    logic [STATUS_W-1:0] res_status;
    logic                res_last;
    logic                load_out;
  } stq_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             any_match;
    logic             full;
    logic             le_head;
    logic             le_second;
    logic             more_than_one;
    logic             res_last;
    logic             out_free;
  } stq_sts_t;

endpackage

### hw/rtl/stq_dp.sv
// Datapath: sorted cell array, parallel compares, result and output registers.
module stq_dp
  import stq_pkg::*;
#(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned ID_BITS   = 8,
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  stq_cmd_t             ctl_i,
  output stq_sts_t             sts_o,
  input  logic [CMD_W-1:0]     cmd_i,
  input  logic [ID_BITS-1:0]   timer_id_i,
  input  logic [TIME_BITS-1:0] time_value_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic                 fired_valid_o,
  output logic [ID_BITS-1:0]   fired_id_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic                 queue_empty_o,
  output logic [TIME_BITS-1:0] next_deadline_o,
  output logic                 last_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CMD_W-1:0]     cmd_q;
  logic [ID_BITS-1:0]   id_q;
  logic [TIME_BITS-1:0] time_q;

  logic [TIME_BITS-1:0] dl_q  [DEPTH];
  logic [ID_BITS-1:0]   tid_q [DEPTH];
  logic [CNT_W-1:0]     count_q, count_d;

  logic [DEPTH-1:0] match_q, match_d;
  logic [DEPTH-1:0] le_q, le_d;
  logic [DEPTH-1:0] rem_sel;

  logic                res_fired_q;
  logic [ID_BITS-1:0]  res_id_q;
  logic [STATUS_W-1:0] res_status_q;
  logic                res_last_q;

  logic                 out_valid_q;
  logic                 fired_valid_q;
  logic [ID_BITS-1:0]   fired_id_q;
  logic [STATUS_W-1:0]  status_q;
  logic                 queue_empty_q;
  logic [TIME_BITS-1:0] next_deadline_q;
  logic                 last_q;

  logic out_free;

  always_ff @(posedge clk_i) begin
    if (ctl_i.cap) begin
      cmd_q  <= cmd_i;
      id_q   <= timer_id_i;
      time_q <= time_value_i;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 occ;
    logic                 take_new;
    logic [TIME_BITS-1:0] prev_dl, next_dl;
    logic [ID_BITS-1:0]   prev_id, next_id;

    assign occ        = CNT_W'(i) < count_q;
    assign match_d[i] = occ && (tid_q[i] == id_q);
    assign le_d[i]    = occ && (dl_q[i] <= time_q);
    assign rem_sel[i] = ctl_i.rem_head || (|match_q[i:0]);

    if (i == 0) begin : g_first
      assign take_new = 1'b1;
      assign prev_dl  = time_q;
      assign prev_id  = id_q;
    end else begin : g_inner
      assign take_new = le_q[i-1];
      assign prev_dl  = dl_q[i-1];
      assign prev_id  = tid_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_dl = dl_q[i];
      assign next_id = tid_q[i];
    end else begin : g_body
      assign next_dl = dl_q[i+1];
      assign next_id = tid_q[i+1];
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.ins) begin
        if (!le_q[i]) begin
          dl_q[i]  <= take_new ? time_q : prev_dl;
          tid_q[i] <= take_new ? id_q : prev_id;
        end
      end else if (ctl_i.rem_match || ctl_i.rem_head) begin
        if (rem_sel[i]) begin
          dl_q[i]  <= next_dl;
          tid_q[i] <= next_id;
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctl_i.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctl_i.rem_match || ctl_i.rem_head) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cmp) begin
      match_q <= match_d;
      le_q    <= le_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.set_res) begin
      res_fired_q  <= ctl_i.res_fired;
      res_id_q     <= ctl_i.res_fired ? tid_q[0] : '0;
      res_status_q <= ctl_i.res_status;
      res_last_q   <= ctl_i.res_last;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_out) begin
      fired_valid_q   <= res_fired_q;
      fired_id_q      <= res_id_q;
      status_q        <= res_status_q;
      last_q          <= res_last_q;
      queue_empty_q   <= (count_q == '0);
      next_deadline_q <= (count_q == '0) ? '0 : dl_q[0];
    end
  end

  assign sts_o.cmd           = cmd_q;
  assign sts_o.any_match     = |match_q;
  assign sts_o.full          = (count_q == CNT_W'(DEPTH));
  assign sts_o.le_head       = le_q[0];
  assign sts_o.le_second     = (DEPTH > 1) ? le_q[(DEPTH > 1) ? 1 : 0] : 1'b0;
  assign sts_o.more_than_one = (count_q > CNT_W'(1));
  assign sts_o.res_last      = res_last_q;
  assign sts_o.out_free      = out_free;

  assign out_valid_o     = out_valid_q;
  assign fired_valid_o   = fired_valid_q;
  assign fired_id_o      = fired_id_q;
  assign status_o        = status_q;
  assign queue_empty_o   = queue_empty_q;
  assign next_deadline_o = next_deadline_q;
  assign last_o          = last_q;

endmodule

### hw/rtl/stq_ctrl.sv
// Controller: sequences capture, compare, update and result for each command.
module stq_ctrl
  import stq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  stq_sts_t sts_i,
  output stq_cmd_t ctl_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_DEC  = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.cap = 1'b1;
          state_d   = ST_CMP;
        end
      end
      ST_CMP: begin
        ctl_o.cmp = 1'b1;
        state_d   = ST_DEC;
      end
      ST_DEC: begin
        ctl_o.set_res    = 1'b1;
        ctl_o.res_status = STATUS_OK;
        ctl_o.res_last   = 1'b1;
        case (sts_i.cmd)
          CMD_SCHEDULE: begin
            if (sts_i.any_match) begin
              ctl_o.res_status = STATUS_DUPLICATE;
            end else if (sts_i.full) begin
              ctl_o.res_status = STATUS_FULL;
            end else begin
              ctl_o.ins = 1'b1;
            end
          end
          CMD_CANCEL: begin
            if (sts_i.any_match) begin
              ctl_o.rem_match = 1'b1;
            end else begin
              ctl_o.res_status = STATUS_NOT_QUEUED;
            end
          end
          CMD_RUN: begin
            if (sts_i.le_head) begin
              ctl_o.rem_head  = 1'b1;
              ctl_o.res_fired = 1'b1;
              ctl_o.res_last  = !(sts_i.more_than_one && sts_i.le_second);
            end
          end
          default: begin
            ctl_o.res_status = STATUS_OK;
          end
        endcase
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          ctl_o.load_out = 1'b1;
          state_d        = sts_i.res_last ? ST_IDLE : ST_CMP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

### hw/rtl/sorted_timer_event_queue_top.sv
// Top level of the sorted timer event queue.
//
//   channel  valid        stall        beat fields
//   in       in_valid_i   in_stall_o   cmd_i timer_id_i time_value_i
//   out      out_valid_o  out_stall_i  fired_valid_o fired_id_o status_o
//                                      queue_empty_o next_deadline_o last_o
//
// Schedule, cancel and an empty run each pass through accept, compare over
// all cells at once, update the sorted cells, load the output register.
// In a run that fires timers, every fired timer repeats the compare,
// update and load steps.
// Reset clears the pending count, the output valid and the controller state; the cells need no clearing pass.
// A stall on the output holds the controller in its load step.
`include "sorted_timer_event_queue_top_defines.svh"

module sorted_timer_event_queue_top
  import stq_pkg::*;
#(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned ID_BITS   = 8,
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CMD_W-1:0]     cmd_i,
  input  logic [ID_BITS-1:0]   timer_id_i,
  input  logic [TIME_BITS-1:0] time_value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 fired_valid_o,
  output logic [ID_BITS-1:0]   fired_id_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic                 queue_empty_o,
  output logic [TIME_BITS-1:0] next_deadline_o,
  output logic                 last_o
);

  stq_cmd_t ctl;
  stq_sts_t sts;

  stq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  stq_dp #(
    .DEPTH     (DEPTH),
    .ID_BITS   (ID_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .cmd_i           (cmd_i),
    .timer_id_i      (timer_id_i),
    .time_value_i    (time_value_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .fired_valid_o   (fired_valid_o),
    .fired_id_o      (fired_id_o),
    .status_o        (status_o),
    .queue_empty_o   (queue_empty_o),
    .next_deadline_o (next_deadline_o),
    .last_o          (last_o)
  );

  `STQ_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `STQ_ASSERT_IMPLY(a_nofire_is_last, clk_i, rst_ni, out_valid_o && !fired_valid_o, last_o)
  `STQ_ASSERT_IMPLY(a_error_no_fire, clk_i, rst_ni, out_valid_o && (status_o != STATUS_OK), !fired_valid_o)
  `STQ_ASSERT_IMPLY(a_empty_zero_deadline, clk_i, rst_ni, out_valid_o && queue_empty_o, next_deadline_o == '0)

endmodule

### tb/sv/sorted_timer_event_queue_top_test.sv
// Self-checking testbench for the sorted timer event queue: random beats, predictor, checker.
module sorted_timer_event_queue_top_test;
  import stq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned ID_BITS   = 8;
  localparam int unsigned TIME_BITS = 48;

  localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
  localparam logic [TIME_BITS-1:0] TIME_MAX   = '1;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [ID_BITS-1:0]   tid;
    logic [TIME_BITS-1:0] tval;
  } timer_beat_t;

  typedef struct packed {
    logic                 fired;
    logic [ID_BITS-1:0]   tid;
    logic [STATUS_W-1:0]  status;
    logic                 empty;
    logic [TIME_BITS-1:0] head_dl;
    logic                 fin;
  } timer_result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic [CMD_W-1:0]     cmd_i         = '0;
  logic [ID_BITS-1:0]   timer_id_i    = '0;
  logic [TIME_BITS-1:0] time_value_i  = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic                 fired_valid_o;
  logic [ID_BITS-1:0]   fired_id_o;
  logic [STATUS_W-1:0]  status_o;
  logic                 queue_empty_o;
  logic [TIME_BITS-1:0] next_deadline_o;
  logic                 last_o;

  timer_beat_t   pending_beats[$];
  timer_result_t expected_results[$];

  logic [TIME_BITS-1:0] dl_cells [DEPTH];
  logic [ID_BITS-1:0]   id_cells [DEPTH];
  int                   pend_cnt = 0;

  int unsigned issued_cnt    = 0;
  int unsigned accepted_cnt  = 0;
  int unsigned mismatches    = 0;
  int unsigned send_idle_pct = 28;
  int unsigned recv_idle_pct = 65;
  logic        in_beat       = 1'b0;
  logic        hold_off      = 1'b0;
  event        hold_go;

  sorted_timer_event_queue_top #(
    .DEPTH    (DEPTH),
    .ID_BITS  (ID_BITS),
    .TIME_BITS(TIME_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .timer_id_i     (timer_id_i),
    .time_value_i   (time_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .fired_valid_o  (fired_valid_o),
    .fired_id_o     (fired_id_o),
    .status_o       (status_o),
    .queue_empty_o  (queue_empty_o),
    .next_deadline_o(next_deadline_o),
    .last_o         (last_o)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      dl_cells[i] = '0;
      id_cells[i] = '0;
    end
  end

  task automatic queue_result(input logic fired, input logic [ID_BITS-1:0] tid,
                              input logic [STATUS_W-1:0] status, input logic fin);
    timer_result_t r;
    r.fired   = fired;
    r.tid     = fired ? tid : '0;
    r.status  = status;
    r.empty   = (pend_cnt == 0);
    r.head_dl = (pend_cnt == 0) ? '0 : dl_cells[0];
    r.fin     = fin;
    expected_results.push_back(r);
  endtask

  task automatic remove_cell(input int pos);
    for (int i = pos; i + 1 < pend_cnt; i++) begin
      dl_cells[i] = dl_cells[i + 1];
      id_cells[i] = id_cells[i + 1];
    end
    pend_cnt--;
  endtask

  task automatic predict_timer_beat(input logic [CMD_W-1:0] cmd,
                                    input logic [ID_BITS-1:0] tid,
                                    input logic [TIME_BITS-1:0] tval);
    int hit;
    int pos;
    int fires;
    logic [ID_BITS-1:0] fid;
    hit = -1;
    for (int i = 0; i < pend_cnt; i++) begin
      if (hit < 0 && id_cells[i] == tid) hit = i;
    end
    case (cmd)
      CMD_SCHEDULE: begin
        if (hit >= 0) begin
          queue_result(1'b0, '0, STATUS_DUPLICATE, 1'b1);
        end else if (pend_cnt >= DEPTH) begin
          queue_result(1'b0, '0, STATUS_FULL, 1'b1);
        end else begin
          pos = 0;
          while (pos < pend_cnt && dl_cells[pos] <= tval) pos++;
          for (int i = pend_cnt; i > pos; i--) begin
            dl_cells[i] = dl_cells[i - 1];
            id_cells[i] = id_cells[i - 1];
          end
          dl_cells[pos] = tval;
          id_cells[pos] = tid;
          pend_cnt++;
          queue_result(1'b0, '0, STATUS_OK, 1'b1);
        end
      end
      CMD_CANCEL: begin
        if (hit < 0) begin
          queue_result(1'b0, '0, STATUS_NOT_QUEUED, 1'b1);
        end else begin
          remove_cell(hit);
          queue_result(1'b0, '0, STATUS_OK, 1'b1);
        end
      end
      CMD_RUN: begin
        fires = 0;
        while (pend_cnt > 0 && fires < DEPTH && dl_cells[0] <= tval) begin
          fid = id_cells[0];
          remove_cell(0);
          queue_result(1'b1, fid, STATUS_OK, !(pend_cnt > 0 && dl_cells[0] <= tval));
          fires++;
        end
        if (fires == 0) queue_result(1'b0, '0, STATUS_OK, 1'b1);
      end
      default: begin
        queue_result(1'b0, '0, STATUS_OK, 1'b1);
      end
    endcase
  endtask

  task automatic flag_field(input string field, input logic [63:0] got,
                            input logic [63:0] want);
    mismatches++;
    if (mismatches <= 100) begin
      $display("%0t ERROR %s: got %0h, expected %0h", $time, field, got, want);
    end
  endtask

  task automatic push_beat(input logic [CMD_W-1:0] cmd, input logic [ID_BITS-1:0] tid,
                           input logic [TIME_BITS-1:0] tval);
    timer_beat_t b;
    b.cmd  = cmd;
    b.tid  = tid;
    b.tval = tval;
    pending_beats.push_back(b);
    issued_cnt++;
  endtask

  task automatic add_random_beats(input int unsigned count);
    logic [TIME_BITS-1:0] base;
    logic [TIME_BITS-1:0] now;
    logic [ID_BITS-1:0]   pool_lo;
    logic [ID_BITS-1:0]   tid;
    int unsigned          r;
    for (int unsigned k = 0; k < count; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(3))
          0: base = TIME_BITS'($urandom_range(1000));
          1: base = TIME_MAX - TIME_BITS'($urandom_range(200));
          default: base = TIME_BITS'({$urandom(), $urandom()});
        endcase
        now     = base;
        pool_lo = ID_BITS'($urandom_range(255));
        if (k != 0 && $urandom_range(1) == 0) push_beat(CMD_RUN, '0, TIME_MAX);
      end
      tid = ($urandom_range(99) < 85) ? pool_lo + ID_BITS'($urandom_range(19))
                                      : ID_BITS'($urandom_range(255));
      r = $urandom_range(99);
      if (r < 48) begin
        push_beat(CMD_SCHEDULE, tid, base + TIME_BITS'($urandom_range(60)));
      end else if (r < 66) begin
        push_beat(CMD_CANCEL, tid, TIME_BITS'({$urandom(), $urandom()}));
      end else if (r < 94) begin
        now = now + TIME_BITS'($urandom_range(12));
        push_beat(CMD_RUN, tid, now);
      end else begin
        push_beat(CMD_UNUSED, tid, TIME_BITS'({$urandom(), $urandom()}));
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (accepted_cnt != issued_cnt || expected_results.size() != 0);
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : in_accept
    in_beat <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_timer_beat(cmd_i, timer_id_i, time_value_i);
      accepted_cnt++;
    end
  end

  always @(negedge clk_i) begin : in_driver
    timer_beat_t b;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_beat) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        b = pending_beats.pop_front();
        in_valid_i   <= 1'b1;
        cmd_i        <= b.cmd;
        timer_id_i   <= b.tid;
        time_value_i <= b.tval;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : out_staller
    out_stall_i <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin : out_monitor
    timer_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        flag_field("beat with nothing expected", 64'(fired_id_o), 64'(0));
      end else begin
        want = expected_results.pop_front();
        if (fired_valid_o !== want.fired)
          flag_field("fired_valid", 64'(fired_valid_o), 64'(want.fired));
        if (fired_id_o !== want.tid)
          flag_field("fired_id", 64'(fired_id_o), 64'(want.tid));
        if (status_o !== want.status)
          flag_field("status", 64'(status_o), 64'(want.status));
        if (queue_empty_o !== want.empty)
          flag_field("queue_empty", 64'(queue_empty_o), 64'(want.empty));
        if (next_deadline_o !== want.head_dl)
          flag_field("next_deadline", 64'(next_deadline_o), 64'(want.head_dl));
        if (last_o !== want.fin)
          flag_field("last", 64'(last_o), 64'(want.fin));
      end
    end
  end

  initial begin : hold_window
    @(hold_go);
    hold_off <= 1'b1;
    repeat (250) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #10_000_000;
    $display("sorted_timer_event_queue_top: mismatch");
    $finish;
  end

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_beat(CMD_RUN, '0, '0);
    push_beat(CMD_CANCEL, '1, TIME_MAX);
    push_beat(CMD_SCHEDULE, 8'h00, TIME_MAX);
    push_beat(CMD_SCHEDULE, 8'h00, '0);
    push_beat(CMD_SCHEDULE, 8'hFF, '0);
    push_beat(CMD_SCHEDULE, 8'h01, 48'd5);
    push_beat(CMD_SCHEDULE, 8'h02, 48'd5);
    push_beat(CMD_CANCEL, 8'h00, '0);
    for (int k = 0; k < 13; k++) begin
      push_beat(CMD_SCHEDULE, ID_BITS'(16 + k), TIME_BITS'(100 - k));
    end
    push_beat(CMD_SCHEDULE, 8'h40, 48'd7);
    push_beat(CMD_SCHEDULE, 8'h10, 48'd7);
    push_beat(CMD_UNUSED, 8'hAA, 48'h5555_5555_5555);
    push_beat(CMD_RUN, '0, TIME_MAX);

    add_random_beats(120);
    wait_drained();

    send_idle_pct = 65;
    recv_idle_pct = 28;
    add_random_beats(120);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_beats(110);
    -> hold_go;
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("sorted_timer_event_queue_top: match");
    end else begin
      $display("sorted_timer_event_queue_top: mismatch");
    end
    $finish;
  end

endmodule
